// ===== src/jsjc_pkg.sv =====
// ----------------------------------------------------------------------------
// jsjc_pkg
// Shared constants, register codes and types of the joystick servo jog
// controller.
// ----------------------------------------------------------------------------
package jsjc_pkg;

	localparam int ADC_BITS_DEF = 10;
	localparam int NUM_JOINTS   = 6;
	localparam int NUM_PAIRS    = NUM_JOINTS / 2;
	localparam int GRIP_PAIR    = NUM_PAIRS - 1;
	localparam int JOINT_W      = $clog2(NUM_JOINTS);
	localparam int ANGLE_W      = 8;
	localparam int SPEED_W      = 5;
	localparam int SPD_EXT_W    = SPEED_W + 1;
	localparam int POS_W        = ANGLE_W + 2;
	localparam int THR_W        = 10;
	localparam int STEP_W       = 4;
	localparam int LIMITS_W     = NUM_JOINTS * ANGLE_W;
	localparam int PULSE_W      = 10;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = LIMITS_W;

	// pulse = PULSE_MIN + angle * (PULSE_MAX - PULSE_MIN) / ANGLE_SPAN, floored
	localparam int PULSE_MIN    = 120;
	localparam int PULSE_MAX    = 600;
	localparam int ANGLE_SPAN   = 180;
	localparam int PULSE_SHIFT  = 11;
	localparam int PULSE_MUL    =
		((PULSE_MAX - PULSE_MIN) * (2 ** PULSE_SHIFT) + ANGLE_SPAN - 1) / ANGLE_SPAN;
	localparam int PROD_W       = $clog2((2 ** ANGLE_W - 1) * PULSE_MUL + 1);

	localparam logic [THR_W-1:0]    LOW_THR_RST     = THR_W'(300);
	localparam logic [THR_W-1:0]    HIGH_THR_RST    = THR_W'(750);
	localparam logic [STEP_W-1:0]   MAX_SPEED_RST   = STEP_W'(2);
	localparam logic [STEP_W-1:0]   ACCEL_RST       = STEP_W'(1);
	localparam logic [STEP_W-1:0]   DECEL_RST       = STEP_W'(1);
	localparam logic [LIMITS_W-1:0] MIN_ANGLES_RST  = 48'd22162708264980;
	localparam logic [LIMITS_W-1:0] MAX_ANGLES_RST  = 48'd132545048780960;
	localparam logic [LIMITS_W-1:0] HOME_ANGLES_RST = 48'd77353878855770;

	localparam int RESULT_BITS  = NUM_JOINTS * PULSE_W + 2;
	localparam int RESULT_W     = ((RESULT_BITS + 7) / 8) * 8;
	localparam int RESULT_PAD_W = RESULT_W - RESULT_BITS;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LOW_THR,
		REG_HIGH_THR,
		REG_MAX_SPEED,
		REG_ACCEL,
		REG_DECEL,
		REG_MIN_ANGLES,
		REG_MAX_ANGLES,
		REG_HOME_ANGLES
	} reg_idx_t;

	typedef enum logic [1:0] {
		DLT_NONE,
		DLT_UP,
		DLT_DOWN
	} delta_t;

	typedef struct packed {
		logic [THR_W-1:0]    low_thr;
		logic [THR_W-1:0]    high_thr;
		logic [STEP_W-1:0]   max_speed;
		logic [STEP_W-1:0]   accel;
		logic [STEP_W-1:0]   decel;
		logic [LIMITS_W-1:0] min_angles;
		logic [LIMITS_W-1:0] max_angles;
		logic [LIMITS_W-1:0] home_angles;
	} cfg_t;

	typedef struct packed {
		delta_t [NUM_JOINTS-1:0] delta;
		logic                    active;
		logic                    home;
	} item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [ANGLE_W-1:0] angle;
	} joint_state_t;

	typedef struct packed {
		logic               vld;
		logic [JOINT_W-1:0] joint;
		delta_t             delta;
		logic               active;
		logic               home;
	} issue_t;

	typedef struct packed {
		logic               en;
		logic [JOINT_W-1:0] addr;
		joint_state_t       data;
	} ram_wr_t;

	typedef struct packed {
		logic               vld;
		logic [JOINT_W-1:0] joint;
		logic [PULSE_W-1:0] pulse;
		logic               active;
		logic               home;
	} pulse_res_t;

	typedef struct packed {
		logic [RESULT_PAD_W-1:0]                pad;
		logic                                   homing;
		logic                                   any_active;
		logic [NUM_JOINTS-1:0][PULSE_W-1:0]     pulse;
	} result_t;

	function automatic joint_state_t reset_state(input logic [JOINT_W-1:0] j);
		joint_state_t st;
		st.speed = '0;
		st.angle = HOME_ANGLES_RST[ANGLE_W*j +: ANGLE_W];
		return st;
	endfunction

endpackage

// ===== src/jsjc_decode.sv =====
// ----------------------------------------------------------------------------
// jsjc_decode
// Classifies the six stick samples of one request into per-joint speed
// steps, plus the activity and home flags.
// ----------------------------------------------------------------------------
module jsjc_decode
	import jsjc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic [NUM_JOINTS-1:0][ADC_BITS-1:0] sample,
	input  logic                                home_held,
	input  logic [THR_W-1:0]                    low_thr,
	input  logic [THR_W-1:0]                    high_thr,
	output item_t                               item
);

	localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

	logic [NUM_JOINTS-1:0] below_lo;
	logic [NUM_JOINTS-1:0] above_hi;
	logic [NUM_JOINTS-1:0] below_hi;
	logic [NUM_JOINTS-1:0] above_lo;
	logic [NUM_JOINTS-1:0] deflect;

	always_comb begin
		for (int i = 0; i < NUM_JOINTS; i++) begin
			below_lo[i] = CMP_W'(sample[i]) < CMP_W'(low_thr);
			above_hi[i] = CMP_W'(sample[i]) > CMP_W'(high_thr);
			below_hi[i] = CMP_W'(sample[i]) < CMP_W'(high_thr);
			above_lo[i] = CMP_W'(sample[i]) > CMP_W'(low_thr);
			deflect[i]  = below_lo[i] | above_hi[i];
		end
	end

	always_comb begin
		item.delta  = '{default: DLT_NONE};
		item.active = 1'b0;
		item.home   = home_held;
		for (int p = 0; p < NUM_PAIRS; p++) begin
			if (deflect[2*p] && !deflect[2*p+1]) begin
				item.active     = 1'b1;
				item.delta[2*p] = below_lo[2*p] ? DLT_DOWN : DLT_UP;
			end else if (deflect[2*p+1] && !deflect[2*p]) begin
				item.active = 1'b1;
				if (p == GRIP_PAIR) begin
					// inverted axis: a low sample steps up, a high sample steps down
					if (below_hi[2*p+1]) begin
						item.delta[2*p+1] = DLT_UP;
					end else if (above_lo[2*p+1]) begin
						item.delta[2*p+1] = DLT_DOWN;
					end else begin
						item.delta[2*p+1] = DLT_NONE;
					end
				end else begin
					item.delta[2*p+1] = below_lo[2*p+1] ? DLT_DOWN : DLT_UP;
				end
			end
		end
	end

endmodule

// ===== src/jsjc_state_ram.sv =====
// ----------------------------------------------------------------------------
// jsjc_state_ram
// Joint state memory: one speed and angle word per joint, registered read.
// Entries not yet written read as the reset pose.
// ----------------------------------------------------------------------------
module jsjc_state_ram
	import jsjc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [JOINT_W-1:0] rd_addr,
	output joint_state_t       rd_data,
	input  ram_wr_t            wr
);

	joint_state_t          mem [NUM_JOINTS];
	joint_state_t          rd_word_q;
	logic [NUM_JOINTS-1:0] vld_q;
	logic                  rd_vld_q;
	logic [JOINT_W-1:0]    rd_addr_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : reset_state(rd_addr_q);

endmodule

// ===== src/jsjc_joint_pipe.sv =====
// ----------------------------------------------------------------------------
// jsjc_joint_pipe
// Per-joint update pipeline: s1 takes the memory word, steps, clamps and
// decays the speed, moves and clamps the angle (homing: steps it toward home,
// speed zero), writes the word back; s2 maps the new angle to a pulse count.
// ----------------------------------------------------------------------------
module jsjc_joint_pipe
	import jsjc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  issue_t       issue,
	input  joint_state_t rd_data,
	output ram_wr_t      wr,
	output pulse_res_t   res
);

	logic               vld_s1;
	logic [JOINT_W-1:0] joint_s1;
	delta_t             delta_s1;
	logic               active_s1;
	logic               home_s1;

	logic               vld_s2;
	logic [JOINT_W-1:0] joint_s2;
	logic [ANGLE_W-1:0] angle_s2;
	logic               active_s2;
	logic               home_s2;

	logic signed [SPD_EXT_W-1:0] spd;
	logic signed [SPD_EXT_W-1:0] acc;
	logic signed [SPD_EXT_W-1:0] lim;
	logic signed [SPD_EXT_W-1:0] dec;
	logic signed [SPD_EXT_W-1:0] sum;
	logic signed [SPD_EXT_W-1:0] clp;
	logic signed [POS_W-1:0]     pos;
	logic signed [POS_W-1:0]     lo;
	logic signed [POS_W-1:0]     hi;
	logic [ANGLE_W-1:0]          home_ang;
	joint_state_t                nxt;
	logic [PROD_W-1:0]           prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		joint_s1  <= issue.joint;
		delta_s1  <= issue.delta;
		active_s1 <= issue.active;
		home_s1   <= issue.home;
		joint_s2  <= joint_s1;
		angle_s2  <= nxt.angle;
		active_s2 <= active_s1;
		home_s2   <= home_s1;
	end

	always_comb begin
		spd      = $signed({rd_data.speed[SPEED_W-1], rd_data.speed});
		acc      = $signed(SPD_EXT_W'(cfg.accel));
		lim      = $signed(SPD_EXT_W'(cfg.max_speed));
		dec      = $signed(SPD_EXT_W'(cfg.decel));
		lo       = $signed(POS_W'(cfg.min_angles[ANGLE_W*joint_s1 +: ANGLE_W]));
		hi       = $signed(POS_W'(cfg.max_angles[ANGLE_W*joint_s1 +: ANGLE_W]));
		home_ang = cfg.home_angles[ANGLE_W*joint_s1 +: ANGLE_W];

		case (delta_s1)
			DLT_UP:   sum = spd + acc;
			DLT_DOWN: sum = spd - acc;
			default:  sum = spd;
		endcase

		if (sum < -lim) begin
			clp = -lim;
		end else if (sum > lim) begin
			clp = lim;
		end else begin
			clp = sum;
		end

		// decay in two steps; a positive speed may overshoot and come back
		if (!active_s1) begin
			if (clp > 0) begin
				clp = clp - dec;
			end
			if (clp < 0) begin
				clp = clp + dec;
			end
		end

		pos = $signed({2'b00, rd_data.angle}) + $signed({{(POS_W-SPD_EXT_W){clp[SPD_EXT_W-1]}}, clp});
		if (pos < lo) begin
			pos = lo;
		end else if (pos > hi) begin
			pos = hi;
		end

		if (home_s1) begin
			nxt.speed = '0;
			if (rd_data.angle < home_ang) begin
				nxt.angle = rd_data.angle + ANGLE_W'(1);
			end else if (rd_data.angle > home_ang) begin
				nxt.angle = rd_data.angle - ANGLE_W'(1);
			end else begin
				nxt.angle = rd_data.angle;
			end
		end else begin
			nxt.speed = clp[SPEED_W-1:0];
			nxt.angle = pos[ANGLE_W-1:0];
		end
	end

	assign wr.en   = vld_s1;
	assign wr.addr = joint_s1;
	assign wr.data = nxt;

	assign prod = PROD_W'(angle_s2) * PROD_W'(PULSE_MUL);

	assign res.vld    = vld_s2;
	assign res.joint  = joint_s2;
	assign res.pulse  = PULSE_W'(PULSE_MIN) + PULSE_W'(prod >> PULSE_SHIFT);
	assign res.active = active_s2;
	assign res.home   = home_s2;

endmodule

// ===== src/joystick_servo_jog_controller.sv =====
// ----------------------------------------------------------------------------
// joystick_servo_jog_controller
// Jogs six servo joints from three joysticks and a home button, one request
// per update tick, and returns the six pulse counts of the new pose.
//
//   channel  direction  payload
//   s_*      in         tick: six stick samples, home button
//   m_*      out        six pulse counts, any_active, homing
//   cfg_*    in         register index, write data
//
// The joint state memory is visited one joint a cycle: each joint is read,
// updated and written back. A new request can start as the last joint of
// the previous one is issued. After reset the memory reads as the reset
// pose at rest without a clearing pass. A stalled output holds one result,
// a second one waits in assembly, and one more request is held at the input.
// ----------------------------------------------------------------------------
module joystick_servo_jog_controller
	import jsjc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// base, shoulder, elbow, wrist, rotate, grip axis, home_held
	input  logic [((NUM_JOINTS*ADC_BITS+1+7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// base, shoulder, elbow, wrist, rotate, grip pulse, any_active, homing
	output logic [RESULT_W-1:0]   m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [JOINT_W-1:0] LAST_JOINT = JOINT_W'(NUM_JOINTS - 1);

	cfg_t                                cfg_q;
	logic [NUM_JOINTS-1:0][ADC_BITS-1:0] sample;
	item_t                               item;
	item_t                               pend_q;
	logic                                pend_vld_q;
	item_t                               cur_q;
	logic                                busy_q;
	logic [JOINT_W-1:0]                  cnt_q;
	logic [1:0]                          out_cnt_q;
	logic                                start;
	logic                                s_acc;
	logic                                m_acc;
	issue_t                              issue;
	joint_state_t                        rd_data;
	ram_wr_t                             wr;
	pulse_res_t                          res;
	result_t                             asm_q;
	logic                                asm_full_q;
	logic                                asm_move;
	result_t                             out_q;
	logic                                out_vld_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thr     <= LOW_THR_RST;
			cfg_q.high_thr    <= HIGH_THR_RST;
			cfg_q.max_speed   <= MAX_SPEED_RST;
			cfg_q.accel       <= ACCEL_RST;
			cfg_q.decel       <= DECEL_RST;
			cfg_q.min_angles  <= MIN_ANGLES_RST;
			cfg_q.max_angles  <= MAX_ANGLES_RST;
			cfg_q.home_angles <= HOME_ANGLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_addr))
				REG_LOW_THR:     cfg_q.low_thr     <= cfg_data[THR_W-1:0];
				REG_HIGH_THR:    cfg_q.high_thr    <= cfg_data[THR_W-1:0];
				REG_MAX_SPEED:   cfg_q.max_speed   <= cfg_data[STEP_W-1:0];
				REG_ACCEL:       cfg_q.accel       <= cfg_data[STEP_W-1:0];
				REG_DECEL:       cfg_q.decel       <= cfg_data[STEP_W-1:0];
				REG_MIN_ANGLES:  cfg_q.min_angles  <= cfg_data[LIMITS_W-1:0];
				REG_MAX_ANGLES:  cfg_q.max_angles  <= cfg_data[LIMITS_W-1:0];
				REG_HOME_ANGLES: cfg_q.home_angles <= cfg_data[LIMITS_W-1:0];
				default: ;
			endcase
		end
	end

	// intake
	assign sample = s_tdata[NUM_JOINTS*ADC_BITS-1:0];

	jsjc_decode #(
		.ADC_BITS (ADC_BITS)
	) u_decode (
		.sample    (sample),
		.home_held (s_tdata[NUM_JOINTS*ADC_BITS]),
		.low_thr   (cfg_q.low_thr),
		.high_thr  (cfg_q.high_thr),
		.item      (item)
	);

	assign s_tready = !pend_vld_q;
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign start    = pend_vld_q && (!busy_q || cnt_q == LAST_JOINT) && (out_cnt_q < 2'd2);

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pend_q <= item;
		end
		if (start) begin
			cur_q <= pend_q;
		end
	end

	// joint sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			out_cnt_q  <= '0;
		end else begin
			if (s_acc) begin
				pend_vld_q <= 1'b1;
			end else if (start) begin
				pend_vld_q <= 1'b0;
			end
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_JOINT) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + JOINT_W'(1);
				end
			end
			out_cnt_q <= out_cnt_q + 2'(start) - 2'(m_acc);
		end
	end

	assign issue.vld    = busy_q;
	assign issue.joint  = cnt_q;
	assign issue.delta  = cur_q.delta[cnt_q];
	assign issue.active = cur_q.active;
	assign issue.home   = cur_q.home;

	jsjc_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (busy_q),
		.rd_addr (cnt_q),
		.rd_data (rd_data),
		.wr      (wr)
	);

	jsjc_joint_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.issue   (issue),
		.rd_data (rd_data),
		.wr      (wr),
		.res     (res)
	);

	// result assembly and output register
	assign asm_move = asm_full_q && (!out_vld_q || m_tready);

	always_ff @(posedge clk) begin
		if (res.vld) begin
			asm_q.pulse[res.joint] <= res.pulse;
			if (res.joint == LAST_JOINT) begin
				asm_q.pad        <= '0;
				asm_q.any_active <= res.active && !res.home;
				asm_q.homing     <= res.home;
			end
		end
		if (asm_move) begin
			out_q <= asm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_full_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (res.vld && res.joint == LAST_JOINT) begin
				asm_full_q <= 1'b1;
			end else if (asm_move) begin
				asm_full_q <= 1'b0;
			end
			if (asm_move) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && busy_q) |-> (wr.addr != cnt_q))
		else $error("state read and write hit the same joint");

	a_out_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'd2)
		else $error("more results in flight than buffer slots");

	a_asm_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && res.joint == '0 && asm_full_q) |-> asm_move)
		else $error("new result overwrites an unmoved assembled result");

	a_start_resets_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == '0 && !$past(out_cnt_q[1])))
		else $error("joint sequence started without a free result slot");
`endif

endmodule
